>>> hw/rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types for the packet rule classifier
// Operation codes, the decoded command that crosses the queue, and the
// back-end state type.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int SLOT_W   = 6;
	localparam int PREFIX_W = 6;
	localparam int IN_W     = 224;
	localparam int OUT_W    = 8;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// rule as stored; on lookup the same record carries the packet fields
	// (ports in the *_lo members)
	typedef struct packed {
		logic [31:0]       precedence;
		logic [31:0]       tunnel;
		logic [7:0]        protocol;
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] src_mask;
		logic [ADDR_W-1:0] dst_addr;
		logic [ADDR_W-1:0] dst_mask;
		logic [PORT_W-1:0] src_lo;
		logic [PORT_W-1:0] src_hi;
		logic [PORT_W-1:0] dst_lo;
		logic [PORT_W-1:0] dst_hi;
		logic              has_ports;
	} rule_t;

	typedef struct packed {
		op_t               kind;
		logic              slot_ok;
		logic [SLOT_W-1:0] slot;
		rule_t             body;
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} bst_t;

endpackage

>>> hw/rtl/prc_front.sv
// ----------------------------------------------------------------------------
// prc_front: input stage
// Takes items, decodes the op, turns prefixes into masks, orders port
// ranges and holds the command until the queue has room.
// ----------------------------------------------------------------------------
module prc_front #(
	parameter int RULES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [prc_pkg::IN_W-1:0]      s_tdata,
	output logic                          push,
	output prc_pkg::cmd_t                 cmd,
	input  logic                          q_full
);
	import prc_pkg::*;

	logic        v_s1;
	cmd_t        cmd_s1;
	cmd_t        dec;
	logic [15:0] sp_a, sp_b, dp_a, dp_b;

	function automatic logic [ADDR_W-1:0] mask_of(input logic [PREFIX_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len >= PREFIX_W'(ADDR_W)) m = '1;
		else m = ~({ADDR_W{1'b1}} >> len);
		return m;
	endfunction

	assign sp_a = s_tdata[171:156];
	assign sp_b = s_tdata[187:172];
	assign dp_a = s_tdata[203:188];
	assign dp_b = s_tdata[219:204];

	always_comb begin
		dec                = '0;
		dec.kind           = op_t'(s_tdata[1:0]);
		dec.slot           = s_tdata[7:2];
		dec.slot_ok        = 32'(s_tdata[7:2]) < 32'(RULES);
		dec.body.precedence = s_tdata[39:8];
		dec.body.tunnel    = s_tdata[71:40];
		dec.body.protocol  = s_tdata[79:72];
		dec.body.src_addr  = s_tdata[111:80];
		dec.body.src_mask  = mask_of(s_tdata[117:112]);
		dec.body.dst_addr  = s_tdata[149:118];
		dec.body.dst_mask  = mask_of(s_tdata[155:150]);
		dec.body.has_ports = s_tdata[220];
		// swapped ranges are stored in order; a lookup keeps its port in _lo
		if (sp_a > sp_b && dec.kind == OP_INSERT) begin
			dec.body.src_lo = sp_b;
			dec.body.src_hi = sp_a;
		end else begin
			dec.body.src_lo = sp_a;
			dec.body.src_hi = sp_b;
		end
		if (dp_a > dp_b && dec.kind == OP_INSERT) begin
			dec.body.dst_lo = dp_b;
			dec.body.dst_hi = dp_a;
		end else begin
			dec.body.dst_lo = dp_a;
			dec.body.dst_hi = dp_b;
		end
	end

	assign push     = v_s1 && !q_full;
	assign s_tready = !v_s1 || !q_full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= dec;
		end
	end

endmodule

>>> hw/rtl/prc_queue.sv
// ----------------------------------------------------------------------------
// prc_queue: two-entry command queue
// Decouples the input stage from the table engine.
// ----------------------------------------------------------------------------
module prc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  prc_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output prc_pkg::cmd_t head
);
	import prc_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wr_cmd;
	end

endmodule

>>> hw/rtl/prc_back.sv
// ----------------------------------------------------------------------------
// prc_back: rule table engine
// Holds the rule memory, runs inserts and removes, and scans the table
// one rule per cycle for a lookup, keeping the best match so far.
// ----------------------------------------------------------------------------
module prc_back #(
	parameter int RULES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  prc_pkg::cmd_t              head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [prc_pkg::OUT_W-1:0]  m_tdata
);
	import prc_pkg::*;

	localparam int IW = $clog2(RULES);

	rule_t          mem_q [RULES];
	logic [RULES-1:0] valid_q;

	bst_t           st_q, st_nxt;
	logic           start, finish, out_free;
	rule_t          pkt_q;
	logic [IW-1:0]  cnt_q;
	logic           issued_q;
	logic           issue;

	logic           rd_v_s1, rd_vb_s1;
	rule_t          rd_rule_s1;
	logic [IW-1:0]  rd_idx_s1;

	logic           m_v_s2, hit_s2;
	logic [31:0]    prec_s2;
	logic [IW-1:0]  idx_s2;

	logic           found_q;
	logic [31:0]    best_q;
	logic [IW-1:0]  best_idx_q;

	logic           out_v_q, out_status_q;
	logic [SLOT_W-1:0] out_slot_q;

	logic [31:0]    slot_w, best_w;
	logic [IW-1:0]  wr_idx;
	logic           match;

	assign slot_w = 32'(head.slot);
	assign wr_idx = slot_w[IW-1:0];
	assign best_w = 32'(best_idx_q);
	assign out_free = !out_v_q || m_tready;
	assign issue = st_q == ST_SCAN && !issued_q;

	always_comb begin
		logic tun_ok, proto_ok, src_ok, dst_ok, port_ok;
		rule_t r;
		r = rd_rule_s1;
		if (pkt_q.tunnel != '0) tun_ok = r.tunnel == pkt_q.tunnel;
		else tun_ok = r.tunnel == '0 && r.dst_addr == pkt_q.dst_addr;
		proto_ok = r.protocol == '0 || r.protocol == pkt_q.protocol;
		src_ok = r.src_addr == '0 || ((pkt_q.src_addr ^ r.src_addr) & r.src_mask) == '0;
		dst_ok = r.dst_addr == '0 || ((pkt_q.dst_addr ^ r.dst_addr) & r.dst_mask) == '0;
		port_ok = !r.has_ports || (pkt_q.has_ports
			&& pkt_q.src_lo >= r.src_lo && pkt_q.src_lo <= r.src_hi
			&& pkt_q.dst_lo >= r.dst_lo && pkt_q.dst_lo <= r.dst_hi);
		match = rd_vb_s1 && tun_ok && proto_ok && src_ok && dst_ok && port_ok;
	end

	always_comb begin
		pop    = 1'b0;
		start  = 1'b0;
		finish = 1'b0;
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					if (head.kind == OP_LOOKUP) begin
						start  = 1'b1;
						st_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (issued_q && !rd_v_s1 && !m_v_s2 && out_free) begin
					finish = 1'b1;
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			valid_q  <= '0;
			cnt_q    <= '0;
			issued_q <= 1'b0;
			rd_v_s1  <= 1'b0;
			m_v_s2   <= 1'b0;
			found_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q    <= st_nxt;
			rd_v_s1 <= issue;
			m_v_s2  <= rd_v_s1;
			if (pop && head.slot_ok) begin
				if (head.kind == OP_INSERT) valid_q[wr_idx] <= 1'b1;
				else if (head.kind == OP_REMOVE) valid_q[wr_idx] <= 1'b0;
			end
			if (start) begin
				cnt_q    <= '0;
				issued_q <= 1'b0;
				found_q  <= 1'b0;
			end else if (issue) begin
				cnt_q <= cnt_q + IW'(1);
				if (cnt_q == IW'(RULES - 1)) issued_q <= 1'b1;
			end
			if (m_v_s2 && hit_s2 && (!found_q || prec_s2 < best_q)) begin
				found_q <= 1'b1;
			end
			if ((pop && head.kind != OP_LOOKUP) || finish) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == OP_INSERT && head.slot_ok) mem_q[wr_idx] <= head.body;
		if (start) pkt_q <= head.body;
		rd_rule_s1 <= mem_q[cnt_q];
		rd_vb_s1   <= valid_q[cnt_q];
		rd_idx_s1  <= cnt_q;
		hit_s2     <= match;
		prec_s2    <= rd_rule_s1.precedence;
		idx_s2     <= rd_idx_s1;
		if (m_v_s2 && hit_s2 && (!found_q || prec_s2 < best_q)) begin
			best_q     <= prec_s2;
			best_idx_q <= idx_s2;
		end
		if (pop && head.kind != OP_LOOKUP) begin
			out_status_q <= 1'b0;
			out_slot_q   <= '0;
		end else if (finish) begin
			out_status_q <= !found_q;
			out_slot_q   <= found_q ? best_w[SLOT_W-1:0] : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_slot_q, out_status_q};

endmodule

>>> hw/rtl/packet_rule_classifier_top.sv
// ----------------------------------------------------------------------------
// packet_rule_classifier_top: rule table classifier, insert/remove/lookup
// Front stage decodes items into a two-entry queue; the table engine
// executes them and scans the rule memory for lookups.
// ----------------------------------------------------------------------------
// Path: insert, remove and unused ops pass the decode register, the queue
//   and the result register; a lookup also passes the scan read and match stages.
// Throughput: one insert/remove per cycle while results are taken; a lookup holds
//   the engine for the whole scan, set by the one-rule-per-cycle memory read port.
// Reset: arst_n clears all handshake and control state and empties the rule
//   table (valid bits); stored rule fields are left as they are.
module packet_rule_classifier_top #(
	parameter int RULES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[1:0] slot[7:2] precedence[39:8] tunnel_id[71:40] protocol[79:72]
	// src_addr[111:80] src_prefix[117:112] dst_addr[149:118]
	// dst_prefix[155:150] src_ports[187:156] dst_ports[219:188]
	// has_ports[220], zero fill [223:221]
	input  logic [223:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[0] matched_slot[6:1], zero fill [7]
	output logic [7:0]  m_tdata
);
	import prc_pkg::*;

	logic push, q_full, q_empty, pop;
	cmd_t f_cmd, q_head;

	// decode stage
	prc_front #(.RULES(RULES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.cmd      (f_cmd),
		.q_full   (q_full)
	);

	// lets decode and table engine stall independently
	prc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (f_cmd),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	// table memory, scan and output register
	prc_back #(.RULES(RULES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (q_head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> hw/rtl/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker: port-level checks for the classifier
// Watches the result stream over time.
// ----------------------------------------------------------------------------
module prc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// a stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a miss always reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[6:1] == 6'd0)
		else $error("miss with nonzero slot");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == 1'b0)
		else $error("fill bit set");

	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result shown during reset");

endmodule

bind packet_rule_classifier_top prc_checker u_prc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/packet_rule_classifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_rule_classifier_checker: result predictor and comparator
// Watches both streams, keeps a shadow rule table updated by each accepted
// insert and remove, and checks each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module packet_rule_classifier_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [223:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	output int           fail_count,
	output int           pending
);
	import prc_pkg::*;

	// packed lowest field last, matching m_tdata[6:0]
	typedef struct packed {
		logic [5:0] slot;
		logic       status;
	} verdict_t;

	logic        tbl_valid [64];
	logic [31:0] tbl_prec [64], tbl_tun [64], tbl_sa [64], tbl_da [64];
	logic [7:0]  tbl_proto [64];
	logic [5:0]  tbl_sp [64], tbl_dp [64];
	logic [31:0] tbl_sr [64], tbl_dr [64];
	logic        tbl_ports [64];
	verdict_t    verdicts [$];

	assign pending = verdicts.size();

	function automatic logic [31:0] mask_of(logic [5:0] len);
		if (len == 0) return 32'h0;
		if (len >= 32) return 32'hFFFF_FFFF;
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic logic [31:0] sort_range(logic [31:0] r);
		if (r[15:0] > r[31:16]) return {r[15:0], r[31:16]};
		return r;
	endfunction

	function automatic logic in_range(logic [15:0] p, logic [31:0] r);
		return r[15:0] <= p && r[31:16] >= p;
	endfunction

	function automatic logic addr_hit(logic [31:0] pkt, logic [31:0] a, logic [5:0] len);
		if (a == 0 || len == 0) return 1'b1;
		return ((pkt ^ a) & mask_of(len)) == 0;
	endfunction

	// applies one item to the shadow table and returns the expected result
	function automatic verdict_t classify(logic [223:0] d);
		op_t         op;
		logic [5:0]  sl;
		logic [31:0] tun, sa, da, best;
		logic [7:0]  pr;
		logic        found, ok;
		verdict_t    v;
		op    = op_t'(d[1:0]);
		sl    = d[7:2];
		tun   = d[71:40];
		pr    = d[79:72];
		sa    = d[111:80];
		da    = d[149:118];
		v     = '0;
		found = 1'b0;
		best  = '0;
		case (op)
			OP_INSERT: begin
				tbl_valid[sl] = 1'b1;
				tbl_prec[sl]  = d[39:8];
				tbl_tun[sl]   = tun;
				tbl_proto[sl] = pr;
				tbl_sa[sl]    = sa;
				tbl_sp[sl]    = d[117:112];
				tbl_da[sl]    = da;
				tbl_dp[sl]    = d[155:150];
				tbl_sr[sl]    = sort_range(d[187:156]);
				tbl_dr[sl]    = sort_range(d[219:188]);
				tbl_ports[sl] = d[220];
			end
			OP_REMOVE: tbl_valid[sl] = 1'b0;
			OP_LOOKUP: begin
				for (int i = 0; i < 64; i++) begin
					ok = tbl_valid[i];
					if (ok && tun != 0) ok = tbl_tun[i] == tun;
					else if (ok) ok = tbl_tun[i] == 0 && tbl_da[i] == da;
					if (ok && tbl_proto[i] != 0) ok = tbl_proto[i] == pr;
					if (ok) ok = addr_hit(sa, tbl_sa[i], tbl_sp[i]);
					if (ok) ok = addr_hit(da, tbl_da[i], tbl_dp[i]);
					if (ok && tbl_ports[i])
						ok = d[220] && in_range(d[171:156], tbl_sr[i])
							&& in_range(d[203:188], tbl_dr[i]);
					if (ok && (!found || tbl_prec[i] < best)) begin
						found  = 1'b1;
						best   = tbl_prec[i];
						v.slot = i[5:0];
					end
				end
				if (!found) v.status = 1'b1;
			end
			default: ;
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want, got;
		if (!arst_n) begin
			fail_count = 0;
			verdicts.delete();
			for (int i = 0; i < 64; i++) tbl_valid[i] = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = verdict_t'(m_tdata[6:0]);
				if (verdicts.size() == 0) begin
					$error("result 0x%h with no item outstanding", m_tdata);
					fail_count++;
				end else begin
					want = verdicts.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.slot !== want.slot) begin
						$error("matched_slot: expected %0d, got %0d", want.slot, got.slot);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) verdicts.push_back(classify(s_tdata));
		end
	end

endmodule

>>> sim/packet_rule_classifier_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_rule_classifier_top_tb: stream test of the rule classifier
// Directed table edits and lookups, then random rule programs with lookups
// aimed at stored rules, under three idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module packet_rule_classifier_top_tb;
	import prc_pkg::*;

	localparam int WATCHDOG = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;
	int           fail_count, pending;
	int           send_idle = 0, recv_idle = 0;   // percent of idle cycles
	logic         recv_hold = 1'b0;                // long output stall
	int           quiet = 0;

	// recent inserted rules, reused to build lookups that hit
	logic [223:0] known [$];

	packet_rule_classifier_top #(.RULES(64)) uut (.*);

	packet_rule_classifier_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random backpressure
	always @(posedge clk) begin
		m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
	end

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [223:0] pack(op_t op, logic [5:0] sl, logic [31:0] prec,
			logic [31:0] tun, logic [7:0] pr, logic [31:0] sa, logic [5:0] sp,
			logic [31:0] da, logic [5:0] dp, logic [31:0] sr, logic [31:0] dr,
			logic hp);
		return {3'b000, hp, dr, sr, dp, da, sp, sa, pr, tun, prec, sl, op};
	endfunction

	// fully random fields for the given op
	function automatic logic [223:0] rnd_any(op_t op);
		return pack(op, 6'($urandom()), $urandom(), $urandom(), 8'($urandom()), $urandom(),
				6'($urandom()), $urandom(), 6'($urandom()), $urandom(), $urandom(),
				1'($urandom()));
	endfunction

	// one item, held until accepted; gaps drawn from send_idle
	task automatic send(logic [223:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (d[1:0] == OP_INSERT) begin
			known.push_back(d);
			if (known.size() > 16) void'(known.pop_front());
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_port_range();
		case ($urandom_range(3))
			0: return 32'hFFFF_0000;
			1: return $urandom();
			default: begin
				logic [15:0] lo;
				lo = 16'($urandom());
				return {lo + 16'($urandom_range(200)), lo};
			end
		endcase
	endfunction

	// random rule; addresses drawn from a small pool so lookups can hit
	function automatic logic [223:0] rnd_insert();
		logic [31:0] tun, da;
		tun = ($urandom_range(1) == 0) ? 32'd0
				: 32'($urandom_range(3)) | {1'($urandom_range(1)), 31'd0};
		da  = ($urandom_range(7) == 0) ? $urandom() : {24'h0A0000, 8'($urandom_range(3))};
		if ($urandom_range(7) == 0) da = 0;
		return pack(OP_INSERT, 6'($urandom()), $urandom_range(3) == 0 ? $urandom()
				: $urandom_range(7), tun, $urandom_range(1) ? 8'd0 : 8'($urandom_range(6, 17)),
				$urandom_range(2) ? {24'hC0A800, 8'($urandom())} : $urandom(),
				6'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(32)),
				da, 6'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(32)),
				rnd_port_range(), rnd_port_range(), 1'($urandom_range(1)));
	endfunction

	// lookup, mostly derived from a stored rule with small perturbations
	function automatic logic [223:0] rnd_lookup();
		logic [223:0] d;
		if (known.size() == 0 || $urandom_range(4) == 0)
			return rnd_any(OP_LOOKUP);
		d = known[$urandom_range(known.size() - 1)];
		d[1:0] = OP_LOOKUP;
		d[7:2] = 6'($urandom());
		if ($urandom_range(3) == 0) d[79:72] = 8'($urandom_range(6, 17));
		d[111:80] = d[111:80] ^ ($urandom_range(1) ? 32'($urandom_range(255)) : 32'd0);
		d[149:118] = d[149:118] ^ ($urandom_range(3) == 0 ? 32'd1 : 32'd0);
		d[171:156] = d[171:156] + 16'($urandom_range(3)) - 16'd1;
		d[203:188] = d[203:188] + 16'($urandom_range(3)) - 16'd1;
		if ($urandom_range(4) == 0) d[220] = ~d[220];
		return d;
	endfunction

	task automatic random_phase(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 40) send(rnd_insert());
			else if (r < 52) send(rnd_any(OP_REMOVE));
			else if (r < 55) send(rnd_any(OP_NOP));
			else send(rnd_lookup());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table lookup, extremes, both candidate modes
		send(pack(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send(pack(OP_INSERT, 0, 32'd5, 0, 8'd6, 32'hC0A8_0100, 6'd24, 32'h0A00_0001,
				6'd32, 32'h0050_0050, 32'h0000_FFFF, 1));              // swapped dst range
		send(pack(OP_INSERT, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
				6'd63, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
		send(pack(OP_INSERT, 1, 32'd5, 0, 0, 0, 0, 32'h0A00_0001, 0, 0, 0, 0)); // tie
		send(pack(OP_LOOKUP, 0, 0, 0, 8'd6, 32'hC0A8_0177, 0, 32'h0A00_0001, 0,
				32'd80, 32'd1000, 1));
		send(pack(OP_LOOKUP, 0, 0, 0, 8'd17, 32'h0102_0304, 0, 32'h0A00_0001, 0, 0, 0, 0));
		send(pack(OP_LOOKUP, 0, 0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
				0, 32'h0000_FFFF, 32'h0000_FFFF, 1));
		send(pack(OP_LOOKUP, 0, 0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
				0, 32'h0000_FFFF, 32'h0000_FFFF, 0));                 // no L4 header
		send(pack(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(pack(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));       // empty remove
		send(pack(OP_INSERT, 0, 32'd9, 0, 0, 0, 6'd40, 32'h0A00_0001, 0, 0, 0, 0)); // overwrite
		send(pack(OP_NOP, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(pack(OP_LOOKUP, 0, 0, 0, 8'd6, 32'hC0A8_0177, 0, 32'h0A00_0001, 0, 0, 0, 0));
		send({3'b000, {221{1'b1}}} & ~224'd3);                       // all-ones lookup
		drain();

		send_idle = 12; recv_idle = 47;
		random_phase(400);

		// long output stall while items keep coming
		recv_hold <= 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				recv_hold <= 1'b0;
			end
			random_phase(30);
		join
		drain();

		send_idle = 47; recv_idle = 12;
		random_phase(400);
		send_idle = 0; recv_idle = 0;
		random_phase(400);
		drain();
		repeat (100) @(posedge clk);

		if (fail_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
